/* sv/hete_pkg.sv */
// Shared constants, types and helpers for the half-edge table engine.
package hete_pkg;

  // Table geometry and id widths
  localparam int HEDGE_DEPTH    = 1024;
  localparam int VERTEX_ID_BITS = 16;
  localparam int CELL_ID_BITS   = 16;

  localparam int IDX_W  = $clog2(HEDGE_DEPTH);
  localparam int CNT_W  = $clog2(HEDGE_DEPTH + 1);
  // One bit above the index so all ones never equals a real index
  localparam int LINK_W = IDX_W + 1;
  localparam logic [LINK_W-1:0] NO_LINK = '1;

  // Opcodes
  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_REPLACE = 2'd1;
  localparam logic [1:0] OP_JOIN    = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_MISS     = 3'd2;
  localparam logic [2:0] ST_MISS_SIB = 3'd3;
  localparam logic [2:0] ST_BAD      = 3'd4;

  // One table entry
  typedef struct packed {
    logic [CELL_ID_BITS-1:0]   cell_id;
    logic [VERTEX_ID_BITS-1:0] vlo;
    logic [VERTEX_ID_BITS-1:0] vhi;
    logic [LINK_W-1:0]         llo;
    logic [LINK_W-1:0]         lhi;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Captured command transaction
  typedef struct packed {
    logic [1:0]                opcode;
    logic [VERTEX_ID_BITS-1:0] vertex_first;
    logic [VERTEX_ID_BITS-1:0] vertex_second;
    logic [CELL_ID_BITS-1:0]   cell_first;
    logic [CELL_ID_BITS-1:0]   cell_second;
    logic [IDX_W-1:0]          hedge_a;
    logic [IDX_W-1:0]          hedge_b;
    logic                      prefer_dir;
  } cmd_t;

  // Result transaction
  typedef struct packed {
    logic [2:0]       status;
    logic [2:0]       joined_count;
    logic [IDX_W-1:0] new_index;
  } res_t;

  // Table port request from the sequencer
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

  // Read the low or high link slot
  function automatic logic [LINK_W-1:0] get_link(input entry_t e, input logic dir);
    return dir ? e.lhi : e.llo;
  endfunction

  // Write the low or high link slot
  function automatic entry_t put_link(input entry_t e, input logic dir,
                                      input logic [LINK_W-1:0] v);
    entry_t r;
    r = e;
    if (dir) begin
      r.lhi = v;
    end else begin
      r.llo = v;
    end
    return r;
  endfunction

endpackage

/* sv/hete_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module hete_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/hete_ctrl.sv */
// Sequencer and shared compare/update unit for the half-edge table.
module hete_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hete_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              res_valid,
  input  logic              res_take,
  output hete_pkg::res_t    res,
  output hete_pkg::mem_req_t mem,
  input  hete_pkg::entry_t  rd_data
);
  import hete_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CR0    = 4'd1;
  localparam logic [3:0] S_CR1    = 4'd2;
  localparam logic [3:0] S_RP_RD  = 4'd3;
  localparam logic [3:0] S_RP_WR  = 4'd4;
  localparam logic [3:0] S_JN_RX  = 4'd5;
  localparam logic [3:0] S_JN_RY  = 4'd6;
  localparam logic [3:0] S_JN_EV  = 4'd7;
  localparam logic [3:0] S_JN_WX  = 4'd8;
  localparam logic [3:0] S_JN_WY  = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0]       state;
  logic [CNT_W-1:0] cnt;
  cmd_t             req;
  logic [2:0]       status;
  logic [2:0]       joined;
  logic [IDX_W-1:0] new_index;
  logic             side;
  logic [1:0]       pair;
  entry_t           ex;
  entry_t           ey;
  logic             dir_x;

  logic [CNT_W:0]   cnt_plus2;
  logic             table_full;
  logic             a_bad;
  logic             b_bad;
  logic [IDX_W-1:0] rp_idx;
  logic [IDX_W-1:0] x_idx;
  logic [IDX_W-1:0] y_idx;
  logic             vlo_hit;
  logic             vhi_hit;
  entry_t           swapped;
  entry_t           y_base;
  entry_t           new_entry;
  logic             cell_match;
  logic             opt_pref;
  logic             opt_alt;
  logic             pref;

  // Range checks on the incoming transaction
  assign cnt_plus2  = {1'b0, cnt} + (CNT_W + 1)'(2);
  assign table_full = cnt_plus2 > (CNT_W + 1)'(HEDGE_DEPTH);
  assign a_bad      = CNT_W'(cmd.hedge_a) >= cnt;
  assign b_bad      = CNT_W'(cmd.hedge_b) >= cnt;

  // Entry addresses for replace and for the current join pair
  assign rp_idx = req.hedge_a ^ IDX_W'(side);
  assign x_idx  = req.hedge_a ^ IDX_W'(pair[1]);
  assign y_idx  = req.hedge_b ^ IDX_W'(pair[0]);

  // Vertex match and swap
  assign vlo_hit = rd_data.vlo == req.vertex_first;
  assign vhi_hit = !vlo_hit && (rd_data.vhi == req.vertex_first);
  always_comb begin
    swapped = rd_data;
    if (vlo_hit) begin
      swapped.vlo = req.vertex_second;
    end else begin
      swapped.vhi = req.vertex_second;
    end
  end

  // Link checks: x is in ex, y arrives on the read port
  assign pref       = req.prefer_dir;
  assign cell_match = ex.cell_id == rd_data.cell_id;
  assign opt_pref   = (get_link(ex, pref) == NO_LINK) &&
                      (get_link(rd_data, ~pref) == NO_LINK);
  assign opt_alt    = (get_link(ex, ~pref) == NO_LINK) &&
                      (get_link(rd_data, pref) == NO_LINK);

  // A self pair sees the update already made on x
  assign y_base = (x_idx == y_idx) ? ex : ey;

  // Fresh entry for create
  always_comb begin
    new_entry.cell_id = (state == S_CR1) ? req.cell_second : req.cell_first;
    new_entry.vlo     = req.vertex_first;
    new_entry.vhi     = req.vertex_second;
    new_entry.llo     = NO_LINK;
    new_entry.lhi     = NO_LINK;
  end

  // Drive the table port
  always_comb begin
    mem = '0;
    case (state)
      S_CR0: begin
        mem.wr_en   = 1'b1;
        mem.wr_addr = cnt[IDX_W-1:0];
        mem.wr_data = new_entry;
      end
      S_CR1: begin
        mem.wr_en   = 1'b1;
        mem.wr_addr = {cnt[IDX_W-1:1], 1'b1};
        mem.wr_data = new_entry;
      end
      S_RP_RD: begin
        mem.rd_addr = rp_idx;
      end
      S_RP_WR: begin
        mem.wr_en   = vlo_hit || vhi_hit;
        mem.wr_addr = rp_idx;
        mem.wr_data = swapped;
      end
      S_JN_RX: begin
        mem.rd_addr = x_idx;
      end
      S_JN_RY: begin
        mem.rd_addr = y_idx;
      end
      S_JN_WX: begin
        mem.wr_en   = 1'b1;
        mem.wr_addr = x_idx;
        mem.wr_data = put_link(ex, dir_x, {1'b0, y_idx});
      end
      S_JN_WY: begin
        mem.wr_en   = 1'b1;
        mem.wr_addr = y_idx;
        mem.wr_data = put_link(y_base, ~dir_x, {1'b0, x_idx});
      end
      default: begin
        mem = '0;
      end
    endcase
  end

  assign busy             = state != S_IDLE;
  assign res_valid        = state == S_FIN;
  assign res.status       = status;
  assign res.joined_count = joined;
  assign res.new_index    = new_index;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            req       <= cmd;
            status    <= ST_OK;
            joined    <= 3'd0;
            new_index <= '0;
            side      <= 1'b0;
            pair      <= 2'd0;
            case (cmd.opcode)
              OP_CREATE: begin
                if (table_full) begin
                  status <= ST_FULL;
                  state  <= S_FIN;
                end else begin
                  state <= S_CR0;
                end
              end
              OP_REPLACE: begin
                if (a_bad) begin
                  status <= ST_BAD;
                  state  <= S_FIN;
                end else begin
                  state <= S_RP_RD;
                end
              end
              OP_JOIN: begin
                if (a_bad || b_bad) begin
                  status <= ST_BAD;
                  state  <= S_FIN;
                end else begin
                  state <= S_JN_RX;
                end
              end
              default: begin
                status <= ST_BAD;
                state  <= S_FIN;
              end
            endcase
          end
        end
        S_CR0: begin
          state <= S_CR1;
        end
        S_CR1: begin
          new_index <= cnt[IDX_W-1:0];
          cnt       <= cnt + CNT_W'(2);
          state     <= S_FIN;
        end
        S_RP_RD: begin
          state <= S_RP_WR;
        end
        S_RP_WR: begin
          // Miss ends the transaction; a first-half hit moves on to the sibling
          if (!(vlo_hit || vhi_hit)) begin
            status <= side ? ST_MISS_SIB : ST_MISS;
            state  <= S_FIN;
          end else if (!side) begin
            side  <= 1'b1;
            state <= S_RP_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_JN_RX: begin
          state <= S_JN_RY;
        end
        S_JN_RY: begin
          ex    <= rd_data;
          state <= S_JN_EV;
        end
        S_JN_EV: begin
          ey    <= rd_data;
          dir_x <= opt_pref ? pref : ~pref;
          if (cell_match && (opt_pref || opt_alt)) begin
            joined <= joined + 3'd1;
            state  <= S_JN_WX;
          end else if (pair == 2'd3) begin
            state <= S_FIN;
          end else begin
            pair  <= pair + 2'd1;
            state <= S_JN_RX;
          end
        end
        S_JN_WX: begin
          ex    <= put_link(ex, dir_x, {1'b0, y_idx});
          state <= S_JN_WY;
        end
        S_JN_WY: begin
          if (pair == 2'd3) begin
            state <= S_FIN;
          end else begin
            pair  <= pair + 2'd1;
            state <= S_JN_RX;
          end
        end
        S_FIN: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/half_edge_table_engine.sv */
// Half-edge table engine: one command transaction in, one result transaction out.
// A rejected command goes straight to its result; create writes both new entries,
// replace updates the entry and, on a hit, its sibling, and join walks four cross pairs.
// One command at a time: each step is a read or write on the single table port.
// Synchronous reset empties the table (entry count to zero); entry contents
// are not cleared and are never read before being written.
module half_edge_table_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  logic [1:0]                          opcode,
  input  logic [hete_pkg::VERTEX_ID_BITS-1:0] vertex_first,
  input  logic [hete_pkg::VERTEX_ID_BITS-1:0] vertex_second,
  input  logic [hete_pkg::CELL_ID_BITS-1:0]   cell_first,
  input  logic [hete_pkg::CELL_ID_BITS-1:0]   cell_second,
  input  logic [hete_pkg::IDX_W-1:0]          hedge_a,
  input  logic [hete_pkg::IDX_W-1:0]          hedge_b,
  input  logic                                prefer_dir,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [2:0]                          status,
  output logic [2:0]                          joined_count,
  output logic [hete_pkg::IDX_W-1:0]          new_index
);
  import hete_pkg::*;

  cmd_t     cmd;
  logic     start;
  logic     busy;
  logic     res_valid;
  logic     res_take;
  res_t     res;
  res_t     rsp;
  mem_req_t mem;
  entry_t   rd_data;

  // Gather the command transaction
  assign cmd.opcode        = opcode;
  assign cmd.vertex_first  = vertex_first;
  assign cmd.vertex_second = vertex_second;
  assign cmd.cell_first    = cell_first;
  assign cmd.cell_second   = cell_second;
  assign cmd.hedge_a       = hedge_a;
  assign cmd.hedge_b       = hedge_b;
  assign cmd.prefer_dir    = prefer_dir;

  assign cmd_stall = busy;
  assign start     = cmd_valid && !cmd_stall;

  hete_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem       (mem),
    .rd_data   (rd_data)
  );

  hete_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HEDGE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem.wr_en),
    .wr_addr (mem.wr_addr),
    .wr_data (mem.wr_data),
    .rd_addr (mem.rd_addr),
    .rd_data (rd_data)
  );

  // Result register: load when empty or being drained
  assign res_take = res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp <= res;
    end
  end

  assign status       = rsp.status;
  assign joined_count = rsp.joined_count;
  assign new_index    = rsp.new_index;

  // An accepted command keeps the sequencer busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start |=> cmd_stall)
    else $error("sequencer idle right after command accept");

  // The table is written only while a command is in progress
  a_write_when_busy: assert property (@(posedge clk) disable iff (rst)
    mem.wr_en |-> busy)
    else $error("table write with no command in progress");

  // A new result appears only after the sequencer finished a command
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(res_valid))
    else $error("result raised without a finished command");

  // At most four pairs can be joined
  a_join_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (joined_count <= 3'd4))
    else $error("joined count above four");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the half-edge table engine.
`timescale 1ns / 100ps

module tb_top;
  import hete_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         CYCLE_LIMIT  = 500000;
  localparam int         RANDOM_ITEMS = 1930;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         IDLE_PCT     = 26;

  typedef struct {
    cmd_t cmd;
    bit   typed;
    res_t want;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cmd_valid;
  logic                      cmd_stall;
  logic [1:0]                opcode;
  logic [VERTEX_ID_BITS-1:0] vertex_first;
  logic [VERTEX_ID_BITS-1:0] vertex_second;
  logic [CELL_ID_BITS-1:0]   cell_first;
  logic [CELL_ID_BITS-1:0]   cell_second;
  logic [IDX_W-1:0]          hedge_a;
  logic [IDX_W-1:0]          hedge_b;
  logic                      prefer_dir;
  logic                      rsp_valid;
  logic                      rsp_stall;
  logic [2:0]                status;
  logic [2:0]                joined_count;
  logic [IDX_W-1:0]          new_index;

  // Shadow copy of the half-edge table
  logic [CELL_ID_BITS-1:0]   cell_mem [HEDGE_DEPTH];
  logic [VERTEX_ID_BITS-1:0] vlo_mem  [HEDGE_DEPTH];
  logic [VERTEX_ID_BITS-1:0] vhi_mem  [HEDGE_DEPTH];
  logic [LINK_W-1:0]         llo_mem  [HEDGE_DEPTH];
  logic [LINK_W-1:0]         lhi_mem  [HEDGE_DEPTH];
  int                        used_entries = 0;

  stim_row_t stim_table [$];
  res_t      owed_results [$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        hold_left = 0;
  bit        steady = 1'b0;
  bit        hold_request = 1'b0;

  half_edge_table_engine u_top (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .opcode       (opcode),
    .vertex_first (vertex_first),
    .vertex_second(vertex_second),
    .cell_first   (cell_first),
    .cell_second  (cell_second),
    .hedge_a      (hedge_a),
    .hedge_b      (hedge_b),
    .prefer_dir   (prefer_dir),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .joined_count (joined_count),
    .new_index    (new_index)
  );

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [LINK_W-1:0] link_of(int idx, bit dir);
    return dir ? lhi_mem[idx] : llo_mem[idx];
  endfunction

  function automatic void set_link(int idx, bit dir, int target);
    if (dir) begin
      lhi_mem[idx] = LINK_W'(target);
    end else begin
      llo_mem[idx] = LINK_W'(target);
    end
  endfunction

  // Link x and y in the preferred direction, else the reverse one
  function automatic bit link_pair(int x, int y, bit p);
    if (link_of(x, p) == NO_LINK && link_of(y, !p) == NO_LINK) begin
      set_link(x, p, y);
      set_link(y, !p, x);
      return 1'b1;
    end
    if (link_of(x, !p) == NO_LINK && link_of(y, p) == NO_LINK) begin
      set_link(x, !p, y);
      set_link(y, p, x);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Replace the low vertex on a hit, else the high one
  function automatic bit swap_vertex(int idx, logic [VERTEX_ID_BITS-1:0] old_id,
                                     logic [VERTEX_ID_BITS-1:0] new_id);
    if (vlo_mem[idx] == old_id) begin
      vlo_mem[idx] = new_id;
      return 1'b1;
    end
    if (vhi_mem[idx] == old_id) begin
      vhi_mem[idx] = new_id;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Update the shadow table for one command and return its result
  function automatic res_t apply_command(cmd_t c);
    res_t r;
    int   a;
    int   b;
    int   x;
    int   y;
    r = '0;
    a = int'(c.hedge_a);
    b = int'(c.hedge_b);
    case (c.opcode)
      OP_CREATE: begin
        if (used_entries + 2 > HEDGE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int k = 0; k < 2; k++) begin
            cell_mem[used_entries + k] = k ? c.cell_second : c.cell_first;
            vlo_mem[used_entries + k]  = c.vertex_first;
            vhi_mem[used_entries + k]  = c.vertex_second;
            llo_mem[used_entries + k]  = NO_LINK;
            lhi_mem[used_entries + k]  = NO_LINK;
          end
          r.new_index = IDX_W'(used_entries);
          used_entries += 2;
        end
      end
      OP_REPLACE: begin
        if (a >= used_entries) begin
          r.status = ST_BAD;
        end else if (!swap_vertex(a, c.vertex_first, c.vertex_second)) begin
          r.status = ST_MISS;
        end else if (!swap_vertex(a ^ 1, c.vertex_first, c.vertex_second)) begin
          r.status = ST_MISS_SIB;
        end
      end
      OP_JOIN: begin
        if (a >= used_entries || b >= used_entries) begin
          r.status = ST_BAD;
        end else begin
          // Cross pairs in order, each seeing the links made before it
          for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < 2; i++) begin
              x = a ^ j;
              y = b ^ i;
              if (cell_mem[x] == cell_mem[y]) begin
                r.joined_count = r.joined_count + 3'(link_pair(x, y, c.prefer_dir));
              end
            end
          end
        end
      end
      default: begin
        r.status = ST_BAD;
      end
    endcase
    return r;
  endfunction

  function automatic int pick_index();
    if (used_entries > 0 && $urandom_range(9) != 0) begin
      return $urandom_range(used_entries - 1);
    end
    return $urandom_range(HEDGE_DEPTH - 1);
  endfunction

  // Small pools make vertex hits and cell matches common
  function automatic logic [VERTEX_ID_BITS-1:0] random_vertex();
    return $urandom_range(1) ? VERTEX_ID_BITS'($urandom_range(7))
                             : VERTEX_ID_BITS'($urandom);
  endfunction

  function automatic logic [CELL_ID_BITS-1:0] random_cell();
    return ($urandom_range(9) == 0) ? CELL_ID_BITS'($urandom)
                                    : CELL_ID_BITS'($urandom_range(3));
  endfunction

  function automatic cmd_t random_command();
    cmd_t c;
    int   pick;
    c.vertex_first  = random_vertex();
    c.vertex_second = random_vertex();
    c.cell_first    = random_cell();
    c.cell_second   = random_cell();
    c.hedge_a       = IDX_W'($urandom);
    c.hedge_b       = IDX_W'($urandom);
    c.prefer_dir    = 1'($urandom);
    pick = $urandom_range(99);
    if (pick < 2) begin
      c.opcode = OP_UNUSED;
    end else if (pick < 36) begin
      c.opcode = OP_CREATE;
    end else if (pick < 66) begin
      c.opcode  = OP_REPLACE;
      c.hedge_a = IDX_W'(pick_index());
      // Mostly aim the old vertex at one the entry really holds
      if (int'(c.hedge_a) < used_entries && $urandom_range(4) != 0) begin
        c.vertex_first = $urandom_range(1) ? vhi_mem[c.hedge_a] : vlo_mem[c.hedge_a];
      end
    end else begin
      c.opcode  = OP_JOIN;
      c.hedge_a = IDX_W'(pick_index());
      c.hedge_b = IDX_W'(pick_index());
    end
    return c;
  endfunction

  task automatic add_row(input logic [1:0] op,
                         input logic [15:0] v1, v2, c1, c2,
                         input int a, b, input bit p, input bit typed,
                         input logic [2:0] st, input int ni);
    stim_row_t row;
    row.cmd.opcode        = op;
    row.cmd.vertex_first  = v1;
    row.cmd.vertex_second = v2;
    row.cmd.cell_first    = c1;
    row.cmd.cell_second   = c2;
    row.cmd.hedge_a       = IDX_W'(a);
    row.cmd.hedge_b       = IDX_W'(b);
    row.cmd.prefer_dir    = p;
    row.typed             = typed;
    row.want.status       = st;
    row.want.joined_count = '0;
    row.want.new_index    = IDX_W'(ni);
    stim_table.push_back(row);
  endtask

  // Offer one transaction after a random gap; entered and left at a falling edge
  task automatic send_command(input cmd_t c, input bit typed, input res_t want);
    res_t predicted;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid     <= 1'b1;
    opcode        <= c.opcode;
    vertex_first  <= c.vertex_first;
    vertex_second <= c.vertex_second;
    cell_first    <= c.cell_first;
    cell_second   <= c.cell_second;
    hedge_a       <= c.hedge_a;
    hedge_b       <= c.hedge_b;
    prefer_dir    <= c.prefer_dir;
    do @(posedge clk); while (cmd_stall);
    predicted = apply_command(c);
    owed_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  function automatic void check_field(string name, logic [15:0] want_v,
                                      logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name,
               want_v, got_v);
      mismatch_count++;
    end
  endfunction

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d", $time,
                 status);
        mismatch_count++;
      end else begin
        want = owed_results.pop_front();
        check_field("status", 16'(want.status), 16'(status));
        check_field("joined_count", 16'(want.joined_count), 16'(joined_count));
        check_field("new_index", 16'(want.new_index), 16'(new_index));
      end
    end
  end

  // Drive the result stall: random idling, a quiet stretch and one long hold
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin
    rst           = 1'b1;
    cmd_valid     = 1'b0;
    opcode        = OP_CREATE;
    vertex_first  = '0;
    vertex_second = '0;
    cell_first    = '0;
    cell_second   = '0;
    hedge_a       = '0;
    hedge_b       = '0;
    prefer_dir    = 1'b0;

    // Directed rows: empty table, creates at the extremes, joins, replaces
    add_row(OP_REPLACE, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 0, 0, 0, 1, ST_BAD, 0);
    add_row(OP_JOIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 1, ST_BAD, 0);
    add_row(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1023, 1023, 1, 1,
            ST_BAD, 0);
    add_row(OP_CREATE, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 0, 0, 0, 1, ST_OK, 0);
    add_row(OP_CREATE, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 0, 0, 0, 1, ST_OK, 2);
    add_row(OP_CREATE, 16'h0001, 16'h0002, 16'h0000, 16'hFFFF, 1023, 1023, 1, 1,
            ST_OK, 4);
    add_row(OP_JOIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 0, ST_OK, 0);
    add_row(OP_JOIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 3, 1, 0, ST_OK, 0);
    add_row(OP_JOIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4, 2, 0, 0, ST_OK, 0);
    add_row(OP_JOIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 5, 1, 1, 0, ST_OK, 0);
    add_row(OP_JOIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 1, 0, 0, ST_OK, 0);
    add_row(OP_REPLACE, 16'h0000, 16'h1234, 16'h0000, 16'h0000, 0, 0, 0, 1, ST_OK, 0);
    add_row(OP_REPLACE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0, 0, ST_OK, 0);
    add_row(OP_REPLACE, 16'h7777, 16'h0001, 16'h0000, 16'h0000, 3, 0, 0, 1, ST_MISS, 0);
    add_row(OP_REPLACE, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 2, 0, 0, 0, ST_OK, 0);
    add_row(OP_REPLACE, 16'h0001, 16'h0002, 16'h0000, 16'h0000, 6, 0, 0, 1, ST_BAD, 0);
    add_row(OP_JOIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1023, 0, 0, 1, ST_BAD, 0);
    add_row(OP_JOIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 6, 1, 1, ST_BAD, 0);
    add_row(OP_REPLACE, 16'h0001, 16'h0002, 16'h0000, 16'h0000, 1023, 0, 0, 1,
            ST_BAD, 0);
    add_row(OP_CREATE, 16'h0001, 16'h0001, 16'h0005, 16'h0005, 0, 0, 0, 1, ST_OK, 6);
    add_row(OP_JOIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 6, 6, 1, 0, ST_OK, 0);
    add_row(OP_JOIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7, 6, 0, 0, ST_OK, 0);

    // Hold reset at the start, then release it
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    foreach (stim_table[n]) begin
      send_command(stim_table[n].cmd, stim_table[n].typed, stim_table[n].want);
    end

    // Random traffic fills the table past full; one quiet stretch, one long hold
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 600 && n < 800);
      if (n == 1000) begin
        hold_request = 1'b1;
      end
      send_command(random_command(), 1'b0, '0);
    end
    cmd_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (owed_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/hete_pkg.sv
sv/hete_ram.sv
sv/hete_ctrl.sv
sv/half_edge_table_engine.sv
verif/tb_top.sv
